// ===== rtl/overwrite_ring_with_cursors_core_macros.svh =====
// Assertion macros for the sample ring RTL.
`ifndef OVERWRITE_RING_WITH_CURSORS_CORE_MACROS_SVH
`define OVERWRITE_RING_WITH_CURSORS_CORE_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define OWRC_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define OWRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/owrc_pkg.sv =====
// Package with the constants, opcodes and state type of the sample ring.
package owrc_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int MAX_BURST  = 64;

  localparam int ADDR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W   = $clog2(RING_DEPTH + 1);
  localparam int BURST_W = 7;
  localparam int HELD_W  = 13;
  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 64;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OLDEST,
    ST_RESYNC,
    ST_COUNT,
    ST_ADDR,
    ST_RUN,
    ST_DRAIN
  } owrc_state_t;

endpackage

// ===== rtl/owrc_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
module owrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic             re,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

// ===== rtl/overwrite_ring_with_cursors_core.sv =====
// Overwriting sample ring with a reader cursor, built around one sample RAM.
// A write or clear request is taken in idle and gives no result.
// A read request passes through the oldest, resync, count and address steps,
// then issues one RAM read per cycle while the result buffer has room; the
// results follow in order. The input stays stalled through the cycle after the last result is taken.
// Reset zeroes the write count at once; the RAM is not cleared, so there is no pass.
`include "overwrite_ring_with_cursors_core_macros.svh"

module overwrite_ring_with_cursors_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_opcode,
  input  logic [owrc_pkg::WORD_W-1:0]       in_sample_word,
  input  logic [owrc_pkg::TOTAL_W-1:0]      in_reader_cursor,
  input  logic [owrc_pkg::BURST_W-1:0]      in_read_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [owrc_pkg::WORD_W-1:0]       out_sample_out,
  output logic                              out_sample_valid,
  output logic [owrc_pkg::TOTAL_W-1:0]      out_next_cursor,
  output logic [owrc_pkg::TOTAL_W-1:0]      out_dropped_count,
  output logic [owrc_pkg::TOTAL_W-1:0]      out_total_written,
  output logic [owrc_pkg::HELD_W-1:0]       out_held_count,
  output logic                              out_last_of_run
);

  localparam int AW = owrc_pkg::ADDR_W;
  localparam int CW = owrc_pkg::CNT_W;
  localparam int BW = owrc_pkg::BURST_W;
  localparam int TW = owrc_pkg::TOTAL_W;
  localparam int WW = owrc_pkg::WORD_W;

  owrc_pkg::owrc_state_t state_r, state_nxt;

  logic [TW-1:0] total_r;
  logic [AW-1:0] wptr_r;

  logic [TW-1:0] tot_r, cur_r, oldest_r, drop_r, nxt_cur_r;
  logic [CW-1:0] held_r, avail_r;
  logic [AW-1:0] wp_r, rd_addr_r;
  logic [BW-1:0] want_r, n_r, rem_r;

  logic          pend_r, pend_smp_r, pend_last_r;
  logic          skid_vld_r, skid_smp_r, skid_last_r;
  logic [WW-1:0] skid_word_r;
  logic          out_vld_r, out_smp_r, out_last_r;
  logic [WW-1:0] out_word_r;

  logic          accept, wr_en, issue, take, room;
  logic [1:0]    occ;
  logic [WW-1:0] ram_rd, land_word;
  logic [TW-1:0] avail_full;
  logic [CW:0]   addr_calc;
  logic [BW-1:0] want_sat;

  owrc_ram #(
    .WIDTH(WW),
    .DEPTH(owrc_pkg::RING_DEPTH)
  ) u_ram (
    .clk(clk),
    .we (wr_en),
    .wa (wptr_r),
    .wd (in_sample_word),
    .re (issue),
    .ra (rd_addr_r),
    .rd (ram_rd)
  );

  assign take      = out_vld_r && !out_stall;
  assign occ       = 2'(out_vld_r) + 2'(skid_vld_r) + 2'(pend_r);
  assign room      = (occ - 2'(take)) < 2'd2;
  assign land_word = pend_smp_r ? ram_rd : '0;
  assign want_sat  = (in_read_count > BW'(owrc_pkg::MAX_BURST)) ?
                     BW'(owrc_pkg::MAX_BURST) : in_read_count;
  assign avail_full = tot_r - cur_r;
  assign addr_calc = (CW+1)'(wp_r)
                   + ((avail_r > CW'(wp_r)) ? (CW+1)'(owrc_pkg::RING_DEPTH) : '0)
                   - (CW+1)'(avail_r);

  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    unique case (state_r)
      owrc_pkg::ST_IDLE:   in_stall = 1'b0;
      owrc_pkg::ST_RUN:    issue = room;
      owrc_pkg::ST_OLDEST, owrc_pkg::ST_RESYNC, owrc_pkg::ST_COUNT,
      owrc_pkg::ST_ADDR, owrc_pkg::ST_DRAIN: in_stall = 1'b1;
      default:             in_stall = 1'b1;
    endcase
    accept = in_valid && !in_stall;
    wr_en  = accept && (in_opcode == owrc_pkg::OP_WRITE);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      owrc_pkg::ST_IDLE: begin
        if (accept && (in_opcode == owrc_pkg::OP_READ)) begin
          state_nxt = owrc_pkg::ST_OLDEST;
        end
      end
      owrc_pkg::ST_OLDEST: state_nxt = owrc_pkg::ST_RESYNC;
      owrc_pkg::ST_RESYNC: state_nxt = owrc_pkg::ST_COUNT;
      owrc_pkg::ST_COUNT:  state_nxt = owrc_pkg::ST_ADDR;
      owrc_pkg::ST_ADDR:   state_nxt = owrc_pkg::ST_RUN;
      owrc_pkg::ST_RUN: begin
        if (issue && (n_r == '0 || rem_r == BW'(1))) begin
          state_nxt = owrc_pkg::ST_DRAIN;
        end
      end
      owrc_pkg::ST_DRAIN: begin
        if (!out_vld_r && !skid_vld_r && !pend_r) begin
          state_nxt = owrc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = owrc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= owrc_pkg::ST_IDLE;
      total_r <= '0;
      wptr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_opcode == owrc_pkg::OP_WRITE)) begin
        total_r <= total_r + TW'(1);
        wptr_r  <= (wptr_r == AW'(owrc_pkg::RING_DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end else if (accept && (in_opcode == owrc_pkg::OP_CLEAR)) begin
        total_r <= '0;
        wptr_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      owrc_pkg::ST_IDLE: begin
        if (accept) begin
          tot_r  <= total_r;
          wp_r   <= wptr_r;
          cur_r  <= in_reader_cursor;
          want_r <= want_sat;
          held_r <= (total_r < TW'(owrc_pkg::RING_DEPTH)) ?
                    CW'(total_r) : CW'(owrc_pkg::RING_DEPTH);
        end
      end
      owrc_pkg::ST_OLDEST: oldest_r <= tot_r - TW'(held_r);
      owrc_pkg::ST_RESYNC: begin
        if (want_r != '0 && cur_r < oldest_r) begin
          drop_r <= oldest_r - cur_r;
          cur_r  <= oldest_r;
        end else begin
          drop_r <= '0;
          if (want_r != '0 && cur_r > tot_r) begin
            cur_r <= oldest_r;
          end
        end
      end
      owrc_pkg::ST_COUNT: begin
        avail_r <= CW'(avail_full);
        n_r     <= (avail_full < TW'(want_r)) ? BW'(avail_full) : want_r;
      end
      owrc_pkg::ST_ADDR: begin
        nxt_cur_r <= cur_r + TW'(n_r);
        rd_addr_r <= AW'(addr_calc);
        rem_r     <= n_r;
      end
      owrc_pkg::ST_RUN: begin
        if (issue && n_r != '0) begin
          rem_r     <= rem_r - BW'(1);
          rd_addr_r <= (rd_addr_r == AW'(owrc_pkg::RING_DEPTH - 1)) ?
                       '0 : rd_addr_r + AW'(1);
        end
      end
      owrc_pkg::ST_DRAIN: rem_r <= rem_r;
      default: rem_r <= rem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      skid_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      pend_r <= issue;
      if (!out_vld_r || take) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= pend_r;
        end else begin
          out_vld_r  <= pend_r;
        end
      end else if (pend_r) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_smp_r  <= (n_r != '0);
      pend_last_r <= (n_r == '0) || (rem_r == BW'(1));
    end
    if (!out_vld_r || take) begin
      if (skid_vld_r) begin
        out_word_r  <= skid_word_r;
        out_smp_r   <= skid_smp_r;
        out_last_r  <= skid_last_r;
        skid_word_r <= land_word;
        skid_smp_r  <= pend_smp_r;
        skid_last_r <= pend_last_r;
      end else begin
        out_word_r  <= land_word;
        out_smp_r   <= pend_smp_r;
        out_last_r  <= pend_last_r;
      end
    end else if (pend_r) begin
      skid_word_r <= land_word;
      skid_smp_r  <= pend_smp_r;
      skid_last_r <= pend_last_r;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_sample_out    = out_word_r;
  assign out_sample_valid  = out_smp_r;
  assign out_last_of_run   = out_last_r;
  assign out_next_cursor   = nxt_cur_r;
  assign out_dropped_count = drop_r;
  assign out_total_written = tot_r;
  assign out_held_count    = owrc_pkg::HELD_W'(held_r);

  `OWRC_ASSERT(a_skid_behind_out, !skid_vld_r || out_vld_r, "Skid holds a result ahead of the output.")
  `OWRC_ASSERT(a_no_overfill, !(out_vld_r && skid_vld_r && pend_r), "Read data landed with no free slot.")
  `OWRC_ASSERT_IMPL(a_idle_empty, !in_stall, !out_vld_r && !pend_r && !skid_vld_r, "Request taken while results are in flight.")
  `OWRC_ASSERT_IMPL(a_empty_is_last, out_vld_r && !out_smp_r, out_last_r, "A result with no sample is not the last of its read.")

endmodule
